### design/hmu_pkg.sv
// ----------------------------------------------------------------------------
// hmu_pkg
// Shared types and constants of the Hopfield memory with unlearning.
// ----------------------------------------------------------------------------
`default_nettype none

package hmu_pkg;

    // Request codes
    localparam logic [2:0] REQ_STORE   = 3'd0;
    localparam logic [2:0] REQ_LOAD    = 3'd1;
    localparam logic [2:0] REQ_ASYNC   = 3'd2;
    localparam logic [2:0] REQ_UNLEARN = 3'd3;
    localparam logic [2:0] REQ_RECALL  = 3'd4;
    localparam logic [2:0] REQ_CLEAR   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_UNLEARN_STRENGTH = 2'd0;
    localparam logic [1:0] CFG_SETTLE_REPEATS   = 2'd1;
    localparam logic [1:0] CFG_MAX_ITERATIONS   = 2'd2;

    // Configuration reset values
    localparam logic [15:0] STRENGTH_RESET = 16'd1024;
    localparam logic [7:0]  SETTLE_RESET   = 8'd20;
    localparam logic [19:0] ITER_RESET     = 20'd1000000;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] pattern_bits;
        logic [5:0]  start_site;
    } t_hmu_in;

    typedef struct packed {
        logic [63:0] spin_bits;
        logic        flipped;
        logic [5:0]  flipped_site;
        logic        converged;
        logic [19:0] sweep_count;
        logic        saturated;
    } t_hmu_out;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLR,
        OP_PAIR_RD,
        OP_ROW_RD,
        OP_ASYNC_EVAL,
        OP_SYNC_BIT,
        OP_REC_START,
        OP_REC_EVAL,
        OP_FINISH
    } t_hmu_op;

    typedef struct packed {
        t_hmu_op op;
    } t_hmu_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       last_cell;
        logic       last_col;
        logic       row_last;
        logic       unstable;
        logic       scan_last;
        logic       rec_go;
        logic       rec_stop;
        logic       out_free;
    } t_hmu_status;

endpackage

`default_nettype wire

### design/hopfield_memory_with_unlearning_top.sv
// ----------------------------------------------------------------------------
// hopfield_memory_with_unlearning_top
// Hopfield associative memory with Hebbian store, unlearning and recall.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result transaction. The
// NEURONS x NEURONS coupling matrix lives in a single RAM that is walked one
// word per cycle, pausing after each row read for a local field: after reset
// a clearing pass over every coupling runs before the first request is
// taken. Store, unlearn and clear walk the whole matrix; load spins only
// latches the pattern. An async step reads the local field of one site after
// another until a site flips or all sites are scanned, and a recall computes
// one synchronous sweep of all local fields at a time; a fixed point or a
// two-state oscillation ends it early, the remaining sweeps counted, not run.
// A finished result is held in an output register while the next request
// is accepted.
`default_nettype none

module hopfield_memory_with_unlearning_top #(
    parameter int NEURONS       = 64,
    parameter int COUPLING_BITS = 24,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire hmu_pkg::t_hmu_in  i_in_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output hmu_pkg::t_hmu_out      o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [19:0]       i_cfg_data
);

    hmu_pkg::t_hmu_cmd    cmd;
    hmu_pkg::t_hmu_status status;
    logic                 ready;

    hmu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    hmu_datapath #(
        .NEURONS       (NEURONS),
        .COUPLING_BITS (COUPLING_BITS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall)
    );

    assign o_stall     = !ready;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

### design/hmu_ram.sv
// ----------------------------------------------------------------------------
// hmu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hmu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/hmu_ctrl.sv
// ----------------------------------------------------------------------------
// hmu_ctrl
// Request sequencer: issues datapath operations, one state per phase.
// ----------------------------------------------------------------------------
`default_nettype none

module hmu_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire hmu_pkg::t_hmu_status i_status,
    output hmu_pkg::t_hmu_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_PAIR,
        S_PAIR_TAIL,
        S_ROW_RD,
        S_ROW_TAIL,
        S_ROW_EVAL,
        S_REC_CHECK,
        S_REC_EVAL,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    hmu_pkg::t_hmu_op n_op;

    // Next state and operation
    always_comb begin
        n_state = r_state;
        n_op    = hmu_pkg::OP_NONE;
        case (r_state)
            S_INIT: begin
                n_op = hmu_pkg::OP_CLR;
                if (i_status.last_cell) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = hmu_pkg::OP_LATCH;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.req)
                    hmu_pkg::REQ_STORE,
                    hmu_pkg::REQ_UNLEARN: n_state = S_PAIR;
                    hmu_pkg::REQ_CLEAR:   n_state = S_CLEAR;
                    hmu_pkg::REQ_ASYNC:   n_state = S_ROW_RD;
                    hmu_pkg::REQ_RECALL:  n_state = S_REC_CHECK;
                    default:              n_state = S_DONE;
                endcase
            end
            S_CLEAR: begin
                n_op = hmu_pkg::OP_CLR;
                if (i_status.last_cell) n_state = S_DONE;
            end
            S_PAIR: begin
                n_op = hmu_pkg::OP_PAIR_RD;
                if (i_status.last_cell) n_state = S_PAIR_TAIL;
            end
            S_PAIR_TAIL: n_state = S_DONE;
            S_ROW_RD: begin
                n_op = hmu_pkg::OP_ROW_RD;
                if (i_status.last_col) n_state = S_ROW_TAIL;
            end
            S_ROW_TAIL: n_state = S_ROW_EVAL;
            S_ROW_EVAL: begin
                if (i_status.req == hmu_pkg::REQ_ASYNC) begin
                    n_op = hmu_pkg::OP_ASYNC_EVAL;
                    if (i_status.unstable || i_status.scan_last) n_state = S_DONE;
                    else n_state = S_ROW_RD;
                end else begin
                    n_op = hmu_pkg::OP_SYNC_BIT;
                    if (i_status.row_last) n_state = S_REC_EVAL;
                    else n_state = S_ROW_RD;
                end
            end
            S_REC_CHECK: begin
                if (i_status.rec_go) begin
                    n_op    = hmu_pkg::OP_REC_START;
                    n_state = S_ROW_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REC_EVAL: begin
                n_op = hmu_pkg::OP_REC_EVAL;
                if (i_status.rec_stop) n_state = S_DONE;
                else n_state = S_REC_CHECK;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_op    = hmu_pkg::OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register; reset starts the coupling clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_cmd.op = n_op;

endmodule

`default_nettype wire

### design/hmu_datapath.sv
// ----------------------------------------------------------------------------
// hmu_datapath
// Coupling memory, spin registers, field accumulator, recall counters.
// ----------------------------------------------------------------------------
`default_nettype none

module hmu_datapath #(
    parameter int NEURONS       = 64,
    parameter int COUPLING_BITS = 24,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire hmu_pkg::t_hmu_cmd    i_cmd,
    output hmu_pkg::t_hmu_status      o_status,
    input  wire hmu_pkg::t_hmu_in     i_in_data,
    input  wire logic                 i_cfg_valid,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [19:0]          i_cfg_data,
    output hmu_pkg::t_hmu_out         o_out_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall
);

    localparam int IDX_W  = $clog2(NEURONS);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int ACC_W  = COUPLING_BITS + IDX_W + 1;
    localparam int SUM_W  = COUPLING_BITS + FRAC_BITS + 2;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(NEURONS - 1);
    localparam logic [FRAC_BITS:0] STORE_STEP =
        (FRAC_BITS + 1)'((64'd1 << FRAC_BITS) / NEURONS);
    localparam logic signed [SUM_W-1:0] C_MAX =
        {{(SUM_W - COUPLING_BITS + 1){1'b0}}, {(COUPLING_BITS - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] C_MIN = ~C_MAX;

    hmu_pkg::t_hmu_op op;
    assign op = i_cmd.op;

    // Request and configuration registers
    logic [2:0]         r_req;
    logic [NEURONS-1:0] r_pat;
    logic [15:0]        r_strength;
    logic [7:0]         r_rep;
    logic [19:0]        r_max;

    // Spin state and recall bookkeeping
    logic [NEURONS-1:0] r_spin, r_nxt, r_prev;
    logic               r_prev_ok;
    logic [7:0]         r_settle;
    logic [19:0]        r_sweeps;
    logic               r_flipped, r_conv, r_sat;
    logic [IDX_W-1:0]   r_fsite;

    // Walk counters and read pipeline
    logic [IDX_W-1:0]   r_row, r_col, r_row_d, r_col_d, r_scan;
    logic               r_vld_d, r_rmw_d;
    logic signed [ACC_W-1:0] r_acc;
    logic               r_out_vld;
    hmu_pkg::t_hmu_out  r_out;

    // Memory ports
    logic                     rd_en, wr_en;
    logic [ADDR_W-1:0]        rd_addr, wr_addr;
    logic [COUPLING_BITS-1:0] rd_data, wr_data;

    hmu_ram #(
        .WIDTH (COUPLING_BITS),
        .DEPTH (1 << ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Hebbian read-modify-write of one coupling
    logic [39:0]             u_full;
    logic [SUM_W-1:0]        mag;
    logic [NEURONS-1:0]      svec;
    logic                    add_pos, off_diag, clip;
    logic signed [SUM_W-1:0] cur_c, sum_c, sat_c;

    always_comb begin
        u_full   = (40'(r_strength) << 8) >> (24 - FRAC_BITS);
        mag      = (r_req == hmu_pkg::REQ_STORE) ? SUM_W'(STORE_STEP) : SUM_W'(u_full);
        svec     = (r_req == hmu_pkg::REQ_STORE) ? r_pat : r_spin;
        add_pos  = (svec[r_row_d] ~^ svec[r_col_d]) ^ (r_req != hmu_pkg::REQ_STORE);
        off_diag = (r_row_d != r_col_d);
        cur_c    = {{(SUM_W - COUPLING_BITS){rd_data[COUPLING_BITS-1]}}, rd_data};
        sum_c    = add_pos ? cur_c + signed'(mag) : cur_c - signed'(mag);
        clip     = 1'b0;
        sat_c    = sum_c;
        if (sum_c > C_MAX) begin
            sat_c = C_MAX;
            clip  = 1'b1;
        end else if (sum_c < C_MIN) begin
            sat_c = C_MIN;
            clip  = 1'b1;
        end
    end

    assign rd_en   = (op == hmu_pkg::OP_PAIR_RD) || (op == hmu_pkg::OP_ROW_RD);
    assign rd_addr = {r_row, r_col};
    assign wr_en   = (op == hmu_pkg::OP_CLR) || (r_vld_d && r_rmw_d && off_diag);
    assign wr_addr = (op == hmu_pkg::OP_CLR) ? {r_row, r_col} : {r_row_d, r_col_d};
    assign wr_data = (op == hmu_pkg::OP_CLR) ? '0 : sat_c[COUPLING_BITS-1:0];

    // Field term and site stability
    logic signed [ACC_W-1:0] term;
    logic                    unstable, acc_pos;
    assign term     = {{(ACC_W - COUPLING_BITS){rd_data[COUPLING_BITS-1]}}, rd_data};
    assign acc_pos  = !r_acc[ACC_W-1] && (r_acc != '0);
    assign unstable = r_spin[r_row] ? r_acc[ACC_W-1] : acc_pos;

    // Recall sweep evaluation
    logic [19:0] sweeps1, left;
    logic [7:0]  settle1, need, k;
    logic        fixed, cycle2;
    always_comb begin
        sweeps1 = r_sweeps + 20'd1;
        settle1 = r_settle + 8'd1;
        need    = r_rep - settle1;
        left    = r_max - sweeps1;
        k       = (20'(need) < left) ? need : left[7:0];
        fixed   = (r_nxt == r_spin);
        cycle2  = r_prev_ok && (r_nxt == r_prev);
    end

    // Input start site, beyond the last site scans from zero
    logic [IDX_W-1:0] first;
    assign first = ({1'b0, i_in_data.start_site} >= 7'(NEURONS)) ? '0
                   : i_in_data.start_site[IDX_W-1:0];

    // Main registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin     <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_vld_d    <= 1'b0;
            r_rmw_d    <= 1'b0;
            r_out_vld  <= 1'b0;
            r_req      <= '0;
            r_settle   <= '0;
            r_sweeps   <= '0;
            r_prev_ok  <= 1'b0;
            r_sat      <= 1'b0;
            r_flipped  <= 1'b0;
            r_conv     <= 1'b0;
            r_fsite    <= '0;
            r_scan     <= '0;
            r_strength <= hmu_pkg::STRENGTH_RESET;
            r_rep      <= hmu_pkg::SETTLE_RESET;
            r_max      <= hmu_pkg::ITER_RESET;
        end else begin
            // read pipeline
            r_vld_d <= rd_en;
            r_rmw_d <= (op == hmu_pkg::OP_PAIR_RD);
            r_row_d <= r_row;
            r_col_d <= r_col;

            // field accumulation or coupling update from read data
            if (r_vld_d) begin
                if (r_rmw_d) begin
                    if (off_diag && clip) r_sat <= 1'b1;
                end else begin
                    r_acc <= r_spin[r_col_d] ? r_acc + term : r_acc - term;
                end
            end else if (op == hmu_pkg::OP_ROW_RD && r_col == '0) begin
                r_acc <= '0;
            end

            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    hmu_pkg::CFG_UNLEARN_STRENGTH: r_strength <= i_cfg_data[15:0];
                    hmu_pkg::CFG_SETTLE_REPEATS:   r_rep      <= i_cfg_data[7:0];
                    hmu_pkg::CFG_MAX_ITERATIONS:   r_max      <= i_cfg_data;
                    default: ;
                endcase
            end

            // output transaction taken, unless a new result replaces it
            if (r_out_vld && !i_out_stall && op != hmu_pkg::OP_FINISH) r_out_vld <= 1'b0;

            case (op)
                hmu_pkg::OP_LATCH: begin
                    r_req     <= i_in_data.req_type;
                    r_pat     <= i_in_data.pattern_bits[NEURONS-1:0];
                    r_row     <= (i_in_data.req_type == hmu_pkg::REQ_ASYNC) ? first : '0;
                    r_col     <= '0;
                    r_sat     <= 1'b0;
                    r_flipped <= 1'b0;
                    r_fsite   <= '0;
                    r_conv    <= 1'b0;
                    r_settle  <= '0;
                    r_sweeps  <= '0;
                    r_prev_ok <= 1'b0;
                    r_scan    <= '0;
                    if (i_in_data.req_type == hmu_pkg::REQ_LOAD) begin
                        r_spin <= i_in_data.pattern_bits[NEURONS-1:0];
                    end
                end
                hmu_pkg::OP_CLR, hmu_pkg::OP_PAIR_RD: begin
                    if (r_col == LAST) begin
                        r_col <= '0;
                        r_row <= (r_row == LAST) ? '0 : r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                hmu_pkg::OP_ROW_RD: begin
                    r_col <= (r_col == LAST) ? '0 : r_col + 1'b1;
                end
                hmu_pkg::OP_ASYNC_EVAL: begin
                    if (unstable) begin
                        r_spin[r_row] <= ~r_spin[r_row];
                        r_flipped     <= 1'b1;
                        r_fsite       <= r_row;
                    end else begin
                        r_row  <= (r_row == LAST) ? '0 : r_row + 1'b1;
                        r_scan <= r_scan + 1'b1;
                        if (r_scan == LAST) r_conv <= 1'b1;
                    end
                end
                hmu_pkg::OP_SYNC_BIT: begin
                    r_nxt[r_row] <= acc_pos;
                    r_row        <= (r_row == LAST) ? '0 : r_row + 1'b1;
                end
                hmu_pkg::OP_REC_START: begin
                    r_row <= '0;
                    r_col <= '0;
                end
                hmu_pkg::OP_REC_EVAL: begin
                    if (fixed) begin
                        r_settle <= settle1 + k;
                        r_sweeps <= sweeps1 + 20'(k);
                    end else if (cycle2) begin
                        if (!left[0]) r_spin <= r_nxt;
                        r_sweeps <= r_max;
                    end else begin
                        r_prev    <= r_spin;
                        r_prev_ok <= 1'b1;
                        r_spin    <= r_nxt;
                        r_sweeps  <= sweeps1;
                    end
                end
                hmu_pkg::OP_FINISH: begin
                    r_out_vld          <= 1'b1;
                    r_out.spin_bits    <= 64'(r_spin);
                    r_out.flipped      <= r_flipped;
                    r_out.flipped_site <= 6'(r_fsite);
                    r_out.converged    <= (r_req == hmu_pkg::REQ_RECALL)
                                          ? (r_settle >= r_rep) : r_conv;
                    r_out.sweep_count  <= r_sweeps;
                    r_out.saturated    <= r_sat;
                end
                default: ;
            endcase
        end
    end

    // Status toward the controller
    always_comb begin
        o_status.req       = r_req;
        o_status.last_cell = (r_row == LAST) && (r_col == LAST);
        o_status.last_col  = (r_col == LAST);
        o_status.row_last  = (r_row == LAST);
        o_status.unstable  = unstable;
        o_status.scan_last = (r_scan == LAST);
        o_status.rec_go    = (r_settle < r_rep) && (r_sweeps < r_max);
        o_status.rec_stop  = fixed || cycle2;
        o_status.out_free  = !r_out_vld || !i_out_stall;
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Hopfield memory with unlearning. A directed
// table covers reset state, extremes and every request kind. Random phases
// at several register settings follow, one of them with strong unlearning.
// Each result is checked against values typed into the directed table or
// a behavioral model that keeps its own coupling matrix and spin vector.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          N_SITES   = 64;
    localparam longint      W_MAX     = (64'sd1 <<< 23) - 1;
    localparam longint      W_MIN     = -(64'sd1 <<< 23);
    localparam longint      HEBB_STEP = 65536 / N_SITES;
    localparam logic [2:0]  REQ_BAD6  = 3'd6;
    localparam logic [2:0]  REQ_BAD7  = 3'd7;
    localparam int          HOLD_OFF  = 20000;
    localparam longint      CYC_LIMIT = 40_000_000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    hmu_pkg::t_hmu_in    i_in_data;
    logic                o_valid;
    logic                i_stall;
    hmu_pkg::t_hmu_out   o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [19:0]         i_cfg_data;

    hopfield_memory_with_unlearning_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_data   (i_in_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Model state
    longint      weights [N_SITES][N_SITES];
    logic [63:0] model_spins;
    int unsigned strength_q16;
    int unsigned settle_need;
    int unsigned sweep_cap;

    hmu_pkg::t_hmu_out pending_results[$];
    int          err_count;
    bit          quiet;
    bit          hold_req;
    longint      cycles;

    // ------------------------------------------------------------------
    // Behavioral model
    // ------------------------------------------------------------------
    function automatic bit hebb_update(logic [63:0] s, longint amt);
        bit     clip;
        longint v;
        clip = 0;
        for (int i = 0; i < N_SITES; i++) begin
            for (int j = i + 1; j < N_SITES; j++) begin
                v = weights[i][j] + ((s[i] == s[j]) ? amt : -amt);
                if (v > W_MAX) begin
                    v = W_MAX;
                    clip = 1;
                end else if (v < W_MIN) begin
                    v = W_MIN;
                    clip = 1;
                end
                weights[i][j] = v;
                weights[j][i] = v;
            end
        end
        return clip;
    endfunction

    function automatic longint site_field(int i, logic [63:0] s);
        longint f;
        f = 0;
        for (int j = 0; j < N_SITES; j++)
            f += s[j] ? weights[i][j] : -weights[i][j];
        return f;
    endfunction

    function automatic logic [63:0] sync_sweep(logic [63:0] s);
        logic [63:0] n;
        n = '0;
        for (int i = 0; i < N_SITES; i++)
            n[i] = (site_field(i, s) > 0);
        return n;
    endfunction

    function automatic hmu_pkg::t_hmu_out predict_result(hmu_pkg::t_hmu_in x);
        hmu_pkg::t_hmu_out r;
        logic [63:0] cur, prv, nxt;
        bit          prv_ok;
        int unsigned sc, sw, need, left, k;
        int          site;
        longint      f;
        r = '0;
        case (x.req_type)
            hmu_pkg::REQ_STORE:
                r.saturated = hebb_update(x.pattern_bits, HEBB_STEP);
            hmu_pkg::REQ_LOAD:
                model_spins = x.pattern_bits;
            hmu_pkg::REQ_UNLEARN:
                r.saturated = hebb_update(model_spins, -longint'(strength_q16));
            hmu_pkg::REQ_CLEAR: begin
                for (int i = 0; i < N_SITES; i++)
                    for (int j = 0; j < N_SITES; j++)
                        weights[i][j] = 0;
            end
            hmu_pkg::REQ_ASYNC: begin
                r.converged = 1;
                for (int kk = 0; kk < N_SITES; kk++) begin
                    site = (x.start_site + kk) % N_SITES;
                    f = site_field(site, model_spins);
                    if ((model_spins[site] && f < 0) || (!model_spins[site] && f > 0)) begin
                        model_spins[site] = ~model_spins[site];
                        r.flipped = 1;
                        r.flipped_site = site[5:0];
                        r.converged = 0;
                        break;
                    end
                end
            end
            hmu_pkg::REQ_RECALL: begin
                cur = model_spins;
                prv = '0;
                prv_ok = 0;
                sc = 0;
                sw = 0;
                while (sc < settle_need && sw < sweep_cap) begin
                    nxt = sync_sweep(cur);
                    sw++;
                    if (nxt == cur) begin
                        // fixed point: count the remaining sweeps as unchanged
                        sc++;
                        need = settle_need - sc;
                        left = sweep_cap - sw;
                        k = (need < left) ? need : left;
                        sc += k;
                        sw += k;
                        break;
                    end
                    if (prv_ok && nxt == prv) begin
                        // period two: parity of the remaining sweeps decides
                        left = sweep_cap - sw;
                        cur = left[0] ? cur : nxt;
                        sw = sweep_cap;
                        break;
                    end
                    prv = cur;
                    prv_ok = 1;
                    cur = nxt;
                end
                model_spins = cur;
                r.converged = (sc >= settle_need);
                r.sweep_count = sw[19:0];
            end
            default: ;
        endcase
        r.spin_bits = model_spins;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYC_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        i_stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_stall <= 1;
                repeat (HOLD_OFF - 1) @(posedge i_clk);
            end else begin
                i_stall <= i_rst_n && !quiet && ($urandom_range(99) < 27);
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    initial begin
        hmu_pkg::t_hmu_out e;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no prediction pending: %h", o_out_data);
                    err_count++;
                end else begin
                    e = pending_results.pop_front();
                    if (o_out_data.spin_bits !== e.spin_bits) begin
                        $error("spin_bits exp %h got %h", e.spin_bits, o_out_data.spin_bits);
                        err_count++;
                    end
                    if (o_out_data.flipped !== e.flipped) begin
                        $error("flipped exp %0d got %0d", e.flipped, o_out_data.flipped);
                        err_count++;
                    end
                    if (o_out_data.flipped_site !== e.flipped_site) begin
                        $error("flipped_site exp %0d got %0d",
                               e.flipped_site, o_out_data.flipped_site);
                        err_count++;
                    end
                    if (o_out_data.converged !== e.converged) begin
                        $error("converged exp %0d got %0d", e.converged, o_out_data.converged);
                        err_count++;
                    end
                    if (o_out_data.sweep_count !== e.sweep_count) begin
                        $error("sweep_count exp %0d got %0d",
                               e.sweep_count, o_out_data.sweep_count);
                        err_count++;
                    end
                    if (o_out_data.saturated !== e.saturated) begin
                        $error("saturated exp %0d got %0d", e.saturated, o_out_data.saturated);
                        err_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one request; the prediction is queued at the accepting edge.
    task automatic send_request(hmu_pkg::t_hmu_in x, hmu_pkg::t_hmu_out e);
        while (!quiet && $urandom_range(99) < 27) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid   <= 1;
        i_in_data <= x;
        forever begin
            @(negedge i_clk);
            if (!o_stall) begin
                pending_results.push_back(e);
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    task automatic issue(logic [2:0] req, logic [63:0] pat, logic [5:0] site);
        hmu_pkg::t_hmu_in x;
        x.req_type = req;
        x.pattern_bits = pat;
        x.start_site = site;
        send_request(x, predict_result(x));
    endtask

    task automatic drain();
        i_valid <= 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
        i_cfg_valid <= 0;
        case (idx)
            hmu_pkg::CFG_UNLEARN_STRENGTH: strength_q16 = val[15:0];
            hmu_pkg::CFG_SETTLE_REPEATS:   settle_need  = val[7:0];
            hmu_pkg::CFG_MAX_ITERATIONS:   sweep_cap    = val;
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [2:0] rand_req(int unlearn_pct);
        int p;
        p = $urandom_range(99);
        if (p < unlearn_pct) return hmu_pkg::REQ_UNLEARN;
        p = $urandom_range(99);
        if (p < 20) return hmu_pkg::REQ_STORE;
        if (p < 35) return hmu_pkg::REQ_LOAD;
        if (p < 60) return hmu_pkg::REQ_ASYNC;
        if (p < 78) return hmu_pkg::REQ_RECALL;
        if (p < 86) return hmu_pkg::REQ_UNLEARN;
        if (p < 92) return hmu_pkg::REQ_CLEAR;
        return (p < 96) ? REQ_BAD6 : REQ_BAD7;
    endfunction

    // Directed table: expected values are filled in only where obvious
    typedef struct {
        logic [2:0]  req;
        logic [63:0] pat;
        logic [5:0]  site;
        bit          typed;
        logic [63:0] e_spins;
        bit          e_conv;
        logic [19:0] e_sweeps;
    } t_dir_row;

    t_dir_row dir_table[22] = '{
        '{hmu_pkg::REQ_ASYNC, 64'h0, 6'd0, 1, 64'h0, 1, 20'd0},
        '{hmu_pkg::REQ_RECALL, 64'h0, 6'd0, 1, 64'h0, 1, 20'd20},
        '{hmu_pkg::REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63,
          1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 20'd0},
        '{REQ_BAD6, 64'h1234_5678_9ABC_DEF0, 6'd7, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 20'd0},
        '{hmu_pkg::REQ_LOAD, 64'h0, 6'd0, 1, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_STORE, 64'h0F0F_0F0F_0F0F_0F0F, 6'd0, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_LOAD, 64'hAAAA_AAAA_AAAA_AABB, 6'd0,
          1, 64'hAAAA_AAAA_AAAA_AABB, 0, 20'd0},
        '{hmu_pkg::REQ_ASYNC, 64'h0, 6'd63, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_ASYNC, 64'h0, 6'd31, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_RECALL, 64'h0, 6'd0, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_UNLEARN, 64'h0, 6'd0, 0, 64'h0, 0, 20'd0},
        '{REQ_BAD7, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_ASYNC, 64'h0, 6'd0, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_CLEAR, 64'h0, 6'd0, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_LOAD, 64'h5555_5555_5555_5555, 6'd0,
          1, 64'h5555_5555_5555_5555, 0, 20'd0},
        '{hmu_pkg::REQ_ASYNC, 64'h0, 6'd5, 1, 64'h5555_5555_5555_5555, 1, 20'd0},
        '{hmu_pkg::REQ_STORE, 64'h5555_5555_5555_5555, 6'd0, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_LOAD, 64'h5555_5555_0055_5555, 6'd0, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_RECALL, 64'h0, 6'd0, 0, 64'h0, 0, 20'd0},
        '{hmu_pkg::REQ_UNLEARN, 64'h0, 6'd0, 0, 64'h0, 0, 20'd0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        hmu_pkg::t_hmu_in  x;
        hmu_pkg::t_hmu_out p, e;
        logic [63:0]       pa, pb;

        err_count    = 0;
        quiet        = 0;
        hold_req     = 0;
        i_rst_n      = 0;
        i_valid      = 0;
        i_in_data    = '0;
        i_cfg_valid  = 0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        model_spins  = '0;
        strength_q16 = hmu_pkg::STRENGTH_RESET;
        settle_need  = hmu_pkg::SETTLE_RESET;
        sweep_cap    = hmu_pkg::ITER_RESET;
        for (int i = 0; i < N_SITES; i++)
            for (int j = 0; j < N_SITES; j++)
                weights[i][j] = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed table at reset settings
        foreach (dir_table[n]) begin
            x.req_type     = dir_table[n].req;
            x.pattern_bits = dir_table[n].pat;
            x.start_site   = dir_table[n].site;
            p = predict_result(x);
            if (dir_table[n].typed) begin
                e = '0;
                e.spin_bits   = dir_table[n].e_spins;
                e.converged   = dir_table[n].e_conv;
                e.sweep_count = dir_table[n].e_sweeps;
            end else begin
                e = p;
            end
            send_request(x, e);
        end
        drain();

        // Low extremes: no unlearning, one sweep per recall
        write_reg(hmu_pkg::CFG_UNLEARN_STRENGTH, 20'd0);
        write_reg(hmu_pkg::CFG_SETTLE_REPEATS, 20'd1);
        write_reg(hmu_pkg::CFG_MAX_ITERATIONS, 20'd1);
        repeat (20) issue(rand_req(0), rand64(), 6'($urandom_range(63)));
        drain();

        // High extremes: strong unlearning on mostly fixed spins
        write_reg(hmu_pkg::CFG_UNLEARN_STRENGTH, 20'd65535);
        write_reg(hmu_pkg::CFG_SETTLE_REPEATS, 20'd255);
        write_reg(hmu_pkg::CFG_MAX_ITERATIONS, 20'hFFFFF);
        quiet = 1;
        issue(hmu_pkg::REQ_CLEAR, 64'h0, 6'd0);
        issue(hmu_pkg::REQ_LOAD, rand64(), 6'd0);
        for (int n = 0; n < 60; n++) begin
            if (n == 20) quiet = 0;
            if ($urandom_range(99) < 85)
                issue(hmu_pkg::REQ_UNLEARN, rand64(), 6'd0);
            else
                issue(($urandom_range(1) != 0) ? hmu_pkg::REQ_ASYNC : hmu_pkg::REQ_RECALL,
                      rand64(), 6'($urandom_range(63)));
        end
        drain();

        // Mid settings: store, noisy load, relax; long output hold-off first
        write_reg(hmu_pkg::CFG_UNLEARN_STRENGTH, 20'($urandom_range(65535)));
        write_reg(hmu_pkg::CFG_SETTLE_REPEATS, 20'($urandom_range(1, 30)));
        write_reg(hmu_pkg::CFG_MAX_ITERATIONS, 20'($urandom_range(1, 40)));
        issue(hmu_pkg::REQ_CLEAR, 64'h0, 6'd0);
        hold_req = 1;
        for (int n = 0; n < 6; n++) begin
            pa = rand64();
            pb = rand64();
            issue(hmu_pkg::REQ_STORE, pa, 6'd0);
            issue(hmu_pkg::REQ_STORE, pb, 6'd0);
            issue(hmu_pkg::REQ_LOAD,
                  pa ^ (64'h1 << $urandom_range(63)) ^ (64'h1 << $urandom_range(63)), 6'd0);
            issue(hmu_pkg::REQ_ASYNC, rand64(), 6'($urandom_range(63)));
            issue(($urandom_range(1) != 0) ? hmu_pkg::REQ_RECALL : hmu_pkg::REQ_UNLEARN,
                  rand64(), 6'd0);
            issue(rand_req(0), rand64(), 6'($urandom_range(63)));
        end
        drain();

        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
design/hmu_pkg.sv
design/hmu_ram.sv
design/hmu_ctrl.sv
design/hmu_datapath.sv
design/hopfield_memory_with_unlearning_top.sv
tb/sv/tb.sv
